[rtl/stfc_pkg.sv]
// ----------------------------------------------------------------------------
// stfc_pkg
// Types, constants and helpers shared by the scalar transport flux cell.
// ----------------------------------------------------------------------------
`default_nettype none

package stfc_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_W  = 48;
  localparam int PSI_W  = 18;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  // limiter constants in unsigned Q2.16, wide enough for psi up to 2.0
  localparam logic [PSI_W-1:0] Q_HALF = 18'h08000;
  localparam logic [PSI_W-1:0] Q_ONE  = 18'h10000;
  localparam logic [PSI_W-1:0] Q_TWO  = 18'h20000;

  localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

  // register indexes
  localparam logic [IDX_W-1:0] REG_CONV_SCHEME    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CONV_ENABLE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIFF_ENABLE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SRC_ENABLE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_FACE_AREA      = 3'd4;
  localparam logic [IDX_W-1:0] REG_INV_CELL_WIDTH = 3'd5;

  // convection schemes
  localparam logic [1:0] SCH_UPWIND   = 2'd0;
  localparam logic [1:0] SCH_SUPERBEE = 2'd1;
  localparam logic [1:0] SCH_CENTRAL  = 2'd2;
  localparam logic [1:0] SCH_NONE     = 2'd3;

  // pipeline latencies
  localparam int DIV_LAT = 19;
  localparam int MUL_LAT = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] phi_west2;
    logic signed [DATA_W-1:0] phi_west;
    logic signed [DATA_W-1:0] phi_center;
    logic signed [DATA_W-1:0] phi_east;
    logic signed [DATA_W-1:0] phi_east2;
    logic signed [DATA_W-1:0] vel_west;
    logic signed [DATA_W-1:0] vel_east;
    logic signed [DATA_W-1:0] lambda_west;
    logic signed [DATA_W-1:0] lambda_center;
    logic signed [DATA_W-1:0] lambda_east;
    logic signed [DATA_W-1:0] source_sum;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] rhs;
    logic signed [OUT_W-1:0] conv_flux;
    logic signed [OUT_W-1:0] diff_flux;
  } result_t;

  // clamp a 50-bit signed value to 48 bits
  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [OUT_W+1:0] v);
    logic ok;
    ok = (v[OUT_W+1:OUT_W-1] == {3{v[OUT_W-1]}});
    if (ok) begin
      sat48 = v[OUT_W-1:0];
    end else if (v[OUT_W+1]) begin
      sat48 = SAT_LO;
    end else begin
      sat48 = SAT_HI;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/stfc_mul.sv]
// ----------------------------------------------------------------------------
// stfc_mul
// Two-stage Q16.16 multiply: 48-bit signed by 33-bit signed, floored, 48-bit sat.
// ----------------------------------------------------------------------------
`default_nettype none

module stfc_mul (
  input  wire logic                                clk,
  input  wire logic signed [stfc_pkg::OUT_W-1:0]   a,
  input  wire logic signed [stfc_pkg::DATA_W:0]    b,
  output logic signed [stfc_pkg::OUT_W-1:0]        p
);
  import stfc_pkg::*;

  localparam int HALF_W = OUT_W / 2;
  localparam int FULL_W = OUT_W + DATA_W + 1;

  logic signed [HALF_W+DATA_W+1:0] p_lo;
  logic signed [HALF_W+DATA_W:0]   p_hi;
  logic signed [FULL_W-1:0]        full;
  logic signed [FULL_W-1:0]        shr;
  logic                            in_range;

  // split partial products
  always_ff @(posedge clk) begin
    p_lo <= $signed({1'b0, a[HALF_W-1:0]}) * b;
    p_hi <= $signed(a[OUT_W-1:HALF_W]) * b;
  end

  always_comb begin
    full     = (FULL_W'(p_hi) <<< HALF_W) + FULL_W'(p_lo);
    shr      = full >>> 16;
    in_range = (shr[FULL_W-1:OUT_W-1] == {(FULL_W-OUT_W+1){shr[OUT_W-1]}});
  end

  always_ff @(posedge clk) begin
    if (in_range) begin
      p <= shr[OUT_W-1:0];
    end else if (shr[FULL_W-1]) begin
      p <= SAT_LO;
    end else begin
      p <= SAT_HI;
    end
  end

endmodule

`default_nettype wire

[rtl/stfc_div.sv]
// ----------------------------------------------------------------------------
// stfc_div
// Pipelined superbee limiter: ratio by restoring division, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stfc_div (
  input  wire logic                                clk,
  input  wire logic                                sb,
  input  wire logic [stfc_pkg::PSI_W-1:0]          base_psi,
  input  wire logic signed [stfc_pkg::DATA_W:0]    num,
  input  wire logic signed [stfc_pkg::DATA_W:0]    den,
  output logic [stfc_pkg::PSI_W-1:0]               psi
);
  import stfc_pkg::*;

  localparam int QB = PSI_W - 1;   // quotient bits below the cap
  localparam int MW = DATA_W + 1;  // magnitude width

  logic [MW-1:0]    un;
  logic [MW-1:0]    ud;
  logic             spec;
  logic [PSI_W-1:0] spec_psi;

  logic [MW:0]      rem  [QB+1];
  logic [MW-1:0]    udp  [QB+1];
  logic [QB-1:0]    q    [QB+1];
  logic             ovr  [QB+1];
  logic             spc  [QB+1];
  logic [PSI_W-1:0] spsi [QB+1];

  logic [PSI_W-1:0] r;

  always_comb begin
    un       = num[DATA_W] ? MW'(-num) : MW'(num);
    ud       = den[DATA_W] ? MW'(-den) : MW'(den);
    spec     = 1'b1;
    spec_psi = '0;
    if (!sb) begin
      spec_psi = base_psi;
    end else if (den == '0) begin
      spec_psi = (!num[DATA_W] && num != '0) ? Q_TWO : '0;
    end else if (num == '0 || num[DATA_W] != den[DATA_W]) begin
      spec_psi = '0;
    end else begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= {1'b0, un};
    udp[0]  <= ud;
    q[0]    <= '0;
    ovr[0]  <= 1'b0;
    spc[0]  <= spec;
    spsi[0] <= spec_psi;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [MW:0] t;
    logic        bit_set;
    logic        over;

    always_comb begin
      if (k == 0) begin
        t    = rem[k];
        over = (rem[k] >= {udp[k], 1'b0});
      end else begin
        t    = {rem[k][MW-1:0], 1'b0};
        over = ovr[k];
      end
      bit_set = (t >= {1'b0, udp[k]});
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= bit_set ? t - {1'b0, udp[k]} : t;
      udp[k+1]  <= udp[k];
      q[k+1]    <= {q[k][QB-2:0], bit_set};
      ovr[k+1]  <= over;
      spc[k+1]  <= spc[k];
      spsi[k+1] <= spsi[k];
    end
  end

  // cap ratio at 2, then superbee: max(min(2r,1), min(r,2))
  always_comb begin
    r = ovr[QB] ? Q_TWO : {1'b0, q[QB]};
  end

  always_ff @(posedge clk) begin
    if (spc[QB]) begin
      psi <= spsi[QB];
    end else if (r <= Q_HALF) begin
      psi <= {r[PSI_W-2:0], 1'b0};
    end else if (r <= Q_ONE) begin
      psi <= Q_ONE;
    end else begin
      psi <= r;
    end
  end

endmodule

`default_nettype wire

[rtl/scalar_transport_flux_cell_top.sv]
// ----------------------------------------------------------------------------
// scalar_transport_flux_cell_top
// One-cell right-hand side of a 1-D finite-volume scalar transport equation.
// ----------------------------------------------------------------------------
// done pulses once for every request taken, in the order taken
// throughput: one request per cycle, busy is low except during reset
// the 17-step limiter divider sets the depth; every unit is fully pipelined
// reset clears the valid pipe and loads register defaults, no clearing pass
// results cannot be stalled: each one shows for a single cycle with done
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_transport_flux_cell_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire stfc_pkg::item_t               item,
  output logic                               done,
  output stfc_pkg::result_t                  result,
  input  wire logic                          cfg_we,
  input  wire logic [stfc_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [stfc_pkg::CFG_W-1:0]    cfg_data
);
  import stfc_pkg::*;

  // stage timing, in edges after the request edge
  localparam int T_PRE  = 1;                   // face selection registered
  localparam int T_PSI  = T_PRE + DIV_LAT;     // limiter out
  localparam int T_FACE = T_PSI + 2;           // face value
  localparam int T_CONV = T_FACE + 2 * MUL_LAT + 1;
  localparam int T_DIFF = T_PRE + 3 * MUL_LAT + 1;
  localparam int LAT    = T_CONV + 1;

  localparam int D_VEL   = T_FACE;
  localparam int D_SRC   = T_CONV;
  localparam int D_DIFF  = T_CONV - T_DIFF;
  localparam int D_DELTA = T_PSI - T_PRE;
  localparam int D_UP    = D_DELTA + 1;

  // configuration registers
  logic [1:0]       face_scheme;
  logic             conv_enable;
  logic             diff_enable;
  logic             src_enable;
  logic [CFG_W-1:0] face_area;
  logic [CFG_W-1:0] inv_cell_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_scheme    <= SCH_UPWIND;
      conv_enable    <= 1'b0;
      diff_enable    <= 1'b0;
      src_enable     <= 1'b1;
      face_area      <= 32'h0001_0000;
      inv_cell_width <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONV_SCHEME:    face_scheme    <= cfg_data[1:0];
        REG_CONV_ENABLE:    conv_enable    <= cfg_data[0];
        REG_DIFF_ENABLE:    diff_enable    <= cfg_data[0];
        REG_SRC_ENABLE:     src_enable     <= cfg_data[0];
        REG_FACE_AREA:      face_area      <= cfg_data;
        REG_INV_CELL_WIDTH: inv_cell_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture and valid pipe
  logic           accept;
  logic [LAT:0]   vpipe;
  item_t          in_q;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= item;
    end
  end

  // stencil, widened for differences
  logic signed [DATA_W:0] pww, pw, pc, pe, pee, lw, lc, le;
  assign pww = (DATA_W+1)'(in_q.phi_west2);
  assign pw  = (DATA_W+1)'(in_q.phi_west);
  assign pc  = (DATA_W+1)'(in_q.phi_center);
  assign pe  = (DATA_W+1)'(in_q.phi_east);
  assign pee = (DATA_W+1)'(in_q.phi_east2);
  assign lw  = (DATA_W+1)'(in_q.lambda_west);
  assign lc  = (DATA_W+1)'(in_q.lambda_center);
  assign le  = (DATA_W+1)'(in_q.lambda_east);

  // face selection: upwind, central and superbee all share
  // face = up + floor(psi * (dn - up) / 2), with psi 0, 1 or the limiter
  logic                   e_pos, w_pos;
  logic signed [DATA_W:0] fe_up, fe_dn, fe_num, fw_up, fw_dn, fw_num;
  logic signed [DATA_W:0] sum_le, sum_lw;

  always_comb begin
    e_pos  = !in_q.vel_east[DATA_W-1];
    w_pos  = !in_q.vel_west[DATA_W-1];
    fe_up  = e_pos ? pc : pe;
    fe_dn  = e_pos ? pe : pc;
    fe_num = e_pos ? pc - pw : pee - pe;
    fw_up  = w_pos ? pw : pc;
    fw_dn  = w_pos ? pc : pw;
    fw_num = w_pos ? pw - pww : pe - pc;
    sum_le = lc + le;
    sum_lw = lc + lw;
  end

  logic signed [DATA_W:0]   p_fe_num, p_fe_den, p_fw_num, p_fw_den;
  logic signed [DATA_W:0]   p_fe_delta, p_fw_delta;
  logic signed [DATA_W-1:0] p_fe_up, p_fw_up;
  logic signed [DATA_W-1:0] p_lf_e, p_lf_w;
  logic                     p_sb;
  logic [PSI_W-1:0]         p_base;

  always_ff @(posedge clk) begin
    p_fe_num   <= fe_num;
    p_fe_den   <= pe - pc;
    p_fw_num   <= fw_num;
    p_fw_den   <= pc - pw;
    p_fe_delta <= fe_dn - fe_up;
    p_fw_delta <= fw_dn - fw_up;
    p_fe_up    <= fe_up[DATA_W-1:0];
    p_fw_up    <= fw_up[DATA_W-1:0];
    p_lf_e     <= sum_le[DATA_W:1];
    p_lf_w     <= sum_lw[DATA_W:1];
    p_sb       <= (face_scheme == SCH_SUPERBEE);
    p_base     <= (face_scheme == SCH_CENTRAL) ? Q_ONE : '0;
  end

  // limiters
  logic [PSI_W-1:0] psi_e, psi_w;

  stfc_div u_div_e (
    .clk      (clk),
    .sb       (p_sb),
    .base_psi (p_base),
    .num      (p_fe_num),
    .den      (p_fe_den),
    .psi      (psi_e)
  );

  stfc_div u_div_w (
    .clk      (clk),
    .sb       (p_sb),
    .base_psi (p_base),
    .num      (p_fw_num),
    .den      (p_fw_den),
    .psi      (psi_w)
  );

  // side data delay lines
  logic signed [DATA_W:0]   dl_fe_delta [D_DELTA];
  logic signed [DATA_W:0]   dl_fw_delta [D_DELTA];
  logic signed [DATA_W-1:0] dl_fe_up    [D_UP];
  logic signed [DATA_W-1:0] dl_fw_up    [D_UP];
  logic signed [DATA_W-1:0] dl_ve       [D_VEL];
  logic signed [DATA_W-1:0] dl_vw       [D_VEL];
  logic signed [DATA_W-1:0] dl_src      [D_SRC];
  logic signed [DATA_W-1:0] dl_lf_e     [MUL_LAT];
  logic signed [DATA_W-1:0] dl_lf_w     [MUL_LAT];
  logic signed [OUT_W-1:0]  dl_diff     [D_DIFF];
  logic signed [OUT_W-1:0]  diff_m;

  always_ff @(posedge clk) begin
    dl_fe_delta[0] <= p_fe_delta;
    dl_fw_delta[0] <= p_fw_delta;
    dl_fe_up[0]    <= p_fe_up;
    dl_fw_up[0]    <= p_fw_up;
    dl_ve[0]       <= in_q.vel_east;
    dl_vw[0]       <= in_q.vel_west;
    dl_src[0]      <= in_q.source_sum;
    dl_lf_e[0]     <= p_lf_e;
    dl_lf_w[0]     <= p_lf_w;
    dl_diff[0]     <= diff_m;
    for (int i = 1; i < D_DELTA; i++) begin
      dl_fe_delta[i] <= dl_fe_delta[i-1];
      dl_fw_delta[i] <= dl_fw_delta[i-1];
    end
    for (int i = 1; i < D_UP; i++) begin
      dl_fe_up[i] <= dl_fe_up[i-1];
      dl_fw_up[i] <= dl_fw_up[i-1];
    end
    for (int i = 1; i < D_VEL; i++) begin
      dl_ve[i] <= dl_ve[i-1];
      dl_vw[i] <= dl_vw[i-1];
    end
    for (int i = 1; i < D_SRC; i++) begin
      dl_src[i] <= dl_src[i-1];
    end
    for (int i = 1; i < MUL_LAT; i++) begin
      dl_lf_e[i] <= dl_lf_e[i-1];
      dl_lf_w[i] <= dl_lf_w[i-1];
    end
    for (int i = 1; i < D_DIFF; i++) begin
      dl_diff[i] <= dl_diff[i-1];
    end
  end

  // face values
  logic signed [PSI_W+DATA_W+1:0] prod_e, prod_w;
  logic signed [PSI_W+DATA_W+1:0] shr_e, shr_w;
  logic signed [DATA_W-1:0]       face_e, face_w;

  always_ff @(posedge clk) begin
    prod_e <= $signed({1'b0, psi_e}) * dl_fe_delta[D_DELTA-1];
    prod_w <= $signed({1'b0, psi_w}) * dl_fw_delta[D_DELTA-1];
  end

  always_comb begin
    shr_e = prod_e >>> (PSI_W - 1);
    shr_w = prod_w >>> (PSI_W - 1);
  end

  always_ff @(posedge clk) begin
    face_e <= dl_fe_up[D_UP-1] + shr_e[DATA_W-1:0];
    face_w <= dl_fw_up[D_UP-1] + shr_w[DATA_W-1:0];
  end

  // convective flux
  logic signed [OUT_W-1:0] cterm_e, cterm_w, conv_net, conv_m;

  stfc_mul u_mul_ce (
    .clk (clk),
    .a   (OUT_W'(face_e)),
    .b   ((DATA_W+1)'(dl_ve[D_VEL-1])),
    .p   (cterm_e)
  );

  stfc_mul u_mul_cw (
    .clk (clk),
    .a   (OUT_W'(face_w)),
    .b   ((DATA_W+1)'(dl_vw[D_VEL-1])),
    .p   (cterm_w)
  );

  always_ff @(posedge clk) begin
    conv_net <= sat48((OUT_W+2)'(cterm_e) - (OUT_W+2)'(cterm_w));
  end

  stfc_mul u_mul_ca (
    .clk (clk),
    .a   (conv_net),
    .b   ($signed({1'b0, face_area})),
    .p   (conv_m)
  );

  // diffusive flux, both gradients use dx
  logic signed [OUT_W-1:0] grad_e, grad_w, dterm_e, dterm_w, diff_net;

  stfc_mul u_mul_ge (
    .clk (clk),
    .a   (OUT_W'(p_fe_den)),
    .b   ($signed({1'b0, inv_cell_width})),
    .p   (grad_e)
  );

  stfc_mul u_mul_gw (
    .clk (clk),
    .a   (OUT_W'(p_fw_den)),
    .b   ($signed({1'b0, inv_cell_width})),
    .p   (grad_w)
  );

  stfc_mul u_mul_de (
    .clk (clk),
    .a   (grad_e),
    .b   ((DATA_W+1)'(dl_lf_e[MUL_LAT-1])),
    .p   (dterm_e)
  );

  stfc_mul u_mul_dw (
    .clk (clk),
    .a   (grad_w),
    .b   ((DATA_W+1)'(dl_lf_w[MUL_LAT-1])),
    .p   (dterm_w)
  );

  always_ff @(posedge clk) begin
    diff_net <= sat48((OUT_W+2)'(dterm_e) - (OUT_W+2)'(dterm_w));
  end

  stfc_mul u_mul_da (
    .clk (clk),
    .a   (diff_net),
    .b   ($signed({1'b0, face_area})),
    .p   (diff_m)
  );

  // combine; scheme code 3 acts as convection off
  logic signed [OUT_W-1:0] conv_v, diff_v, src_v;

  always_comb begin
    conv_v = (conv_enable && face_scheme != SCH_NONE) ? conv_m : '0;
    diff_v = diff_enable ? dl_diff[D_DIFF-1] : '0;
    src_v  = src_enable ? OUT_W'(dl_src[D_SRC-1]) : '0;
  end

  always_ff @(posedge clk) begin
    result.rhs       <= sat48((OUT_W+2)'(diff_v) - (OUT_W+2)'(conv_v) + (OUT_W+2)'(src_v));
    result.conv_flux <= conv_v;
    result.diff_flux <= diff_v;
  end

  assign done = vpipe[LAT];

endmodule

`default_nettype wire

[verif/scalar_transport_flux_cell_top_tb.sv]
// ----------------------------------------------------------------------------
// scalar_transport_flux_cell_top_tb
// Self-checking bench: drives stencil requests under several register
// settings and compares every result against an in-bench flux predictor.
// ----------------------------------------------------------------------------
`default_nettype none

class flux_scoreboard;
  stfc_pkg::result_t pending_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_request(stfc_pkg::result_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function void check_result(stfc_pkg::result_t got);
    stfc_pkg::result_t exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
    end else begin
      exp_r = pending_q.pop_front();
      if (got.rhs !== exp_r.rhs) begin
        $display("%0t: rhs exp %h got %h", $time, exp_r.rhs, got.rhs);
        errors++;
      end
      if (got.conv_flux !== exp_r.conv_flux) begin
        $display("%0t: conv_flux exp %h got %h", $time, exp_r.conv_flux, got.conv_flux);
        errors++;
      end
      if (got.diff_flux !== exp_r.diff_flux) begin
        $display("%0t: diff_flux exp %h got %h", $time, exp_r.diff_flux, got.diff_flux);
        errors++;
      end
    end
  endfunction
endclass

module scalar_transport_flux_cell_top_tb;
  import stfc_pkg::*;

  localparam longint HI48 = 64'sd140737488355327;
  localparam longint LO48 = -64'sd140737488355328;
  localparam int LATENCY = 28;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow copy of the register file
  logic [1:0] sh_scheme;
  logic sh_conv_en, sh_diff_en, sh_src_en;
  logic [31:0] sh_area, sh_inv;

  flux_scoreboard sb;
  bit idle_enable;

  scalar_transport_flux_cell_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // every result is taken at the edge ending its done cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic longint clamp48(longint v);
    if (v > HI48) return HI48;
    if (v < LO48) return LO48;
    return v;
  endfunction

  // floor(x*y/2^16), x clamped to 48 bits, saturated result
  function automatic longint qmul(longint x, longint y);
    logic signed [127:0] p;
    p = 128'(clamp48(x)) * 128'(y);
    p = p >>> 16;
    if (p > 128'(HI48)) return HI48;
    if (p < 128'(LO48)) return LO48;
    return longint'(p);
  endfunction

  // superbee face: up + floor(psi*(dn-up)/2)
  function automatic longint sb_face(longint up, longint dn, longint num, longint den);
    longint psi, r, un, ud;
    if (den == 0) psi = (num > 0) ? 64'sh20000 : 0;
    else if (num == 0 || ((num < 0) != (den < 0))) psi = 0;
    else begin
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      r = (un <<< 16) / ud;
      if (r > 64'sh20000) r = 64'sh20000;
      if (r <= 64'sh8000) psi = 2 * r;
      else if (r <= 64'sh10000) psi = 64'sh10000;
      else psi = r;
    end
    return up + ((psi * (dn - up)) >>> 17);
  endfunction

  function automatic result_t predict_flux(item_t it);
    longint pww, pw, pc, pe, pee, vw, ve, lw, lc, le, src;
    longint area, inv, conv, diff, rhs, fe, fw;
    result_t r;
    pww = it.phi_west2; pw = it.phi_west; pc = it.phi_center;
    pe = it.phi_east; pee = it.phi_east2; vw = it.vel_west; ve = it.vel_east;
    lw = it.lambda_west; lc = it.lambda_center; le = it.lambda_east;
    src = it.source_sum;
    area = longint'({32'd0, sh_area});
    inv = longint'({32'd0, sh_inv});
    conv = 0; diff = 0; fe = 0; fw = 0;
    if (sh_conv_en && sh_scheme != SCH_NONE) begin
      if (sh_scheme == SCH_UPWIND) begin
        fw = (vw >= 0) ? pw : pc;
        fe = (ve >= 0) ? pc : pe;
      end else if (sh_scheme == SCH_SUPERBEE) begin
        fe = (ve >= 0) ? sb_face(pc, pe, pc - pw, pe - pc) : sb_face(pe, pc, pee - pe, pe - pc);
        fw = (vw >= 0) ? sb_face(pw, pc, pw - pww, pc - pw) : sb_face(pc, pw, pe - pc, pc - pw);
      end else begin
        fe = (pc + pe) >>> 1;
        fw = (pc + pw) >>> 1;
      end
      conv = qmul(clamp48(qmul(fe, ve) - qmul(fw, vw)), area);
    end
    if (sh_diff_en) begin
      diff = qmul(clamp48(qmul(qmul(pe - pc, inv), (lc + le) >>> 1)
                        - qmul(qmul(pc - pw, inv), (lc + lw) >>> 1)), area);
    end
    rhs = diff - conv;
    if (sh_src_en) rhs += src;
    rhs = clamp48(rhs);
    r.rhs = rhs[47:0];
    r.conv_flux = conv[47:0];
    r.diff_flux = diff[47:0];
    return r;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // out-of-range index is ignored, values are masked
    case (idx)
      REG_CONV_SCHEME: sh_scheme = val[1:0];
      REG_CONV_ENABLE: sh_conv_en = val[0];
      REG_DIFF_ENABLE: sh_diff_en = val[0];
      REG_SRC_ENABLE: sh_src_en = val[0];
      REG_FACE_AREA: sh_area = val;
      REG_INV_CELL_WIDTH: sh_inv = val;
      default: ;
    endcase
  endtask

  // wait until all results are in, then past the pipe depth
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one request; start stays high across back-to-back requests
  task automatic send_request(item_t it);
    int gap;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(predict_flux(it));
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'(int'($urandom_range(0, 512)) - 256);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return 32'h00010000;
        endcase
      end
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int mode;
    logic [31:0] w[11];
    mode = $urandom_range(0, 9);
    mode = (mode < 2) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    foreach (w[k]) w[k] = ($urandom_range(0, 9) == 0) ? rand_word(3) : rand_word(mode);
    // sometimes equal neighbors to hit zero ratio denominators
    if ($urandom_range(0, 5) == 0) w[3] = w[2];
    if ($urandom_range(0, 5) == 0) w[1] = w[2];
    if ($urandom_range(0, 7) == 0) w[5] = 0;
    if ($urandom_range(0, 7) == 0) w[6] = 0;
    it = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10]};
    return it;
  endfunction

  task automatic random_config();
    write_reg(REG_CONV_SCHEME, $urandom_range(0, 3));
    write_reg(REG_CONV_ENABLE, 32'($urandom_range(0, 4) != 0));
    write_reg(REG_DIFF_ENABLE, 32'($urandom_range(0, 4) != 0));
    write_reg(REG_SRC_ENABLE, $urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: write_reg(REG_FACE_AREA, $urandom());
      1: write_reg(REG_FACE_AREA, 32'hffffffff);
      2: write_reg(REG_FACE_AREA, 32'h0);
      default: write_reg(REG_FACE_AREA, $urandom_range(0, 4 << 16));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_INV_CELL_WIDTH, $urandom());
      1: write_reg(REG_INV_CELL_WIDTH, 32'hffffffff);
      2: write_reg(REG_INV_CELL_WIDTH, 32'h0);
      default: write_reg(REG_INV_CELL_WIDTH, $urandom_range(0, 4 << 16));
    endcase
    // stray write to an unused index must be ignored
    if ($urandom_range(0, 3) == 0) write_reg(3'd6 + 3'($urandom_range(0, 1)), $urandom());
  endtask

  initial begin
    item_t it;
    sb = new();
    sh_scheme = SCH_UPWIND; sh_conv_en = 1'b0; sh_diff_en = 1'b0; sh_src_en = 1'b1;
    sh_area = 32'h10000; sh_inv = 32'h10000;
    idle_enable = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults first, then each scheme with both flux paths on
    it = '0; it.source_sum = 32'h7fffffff;
    send_request(it);
    end_burst();
    drain();
    write_reg(REG_CONV_ENABLE, 1);
    write_reg(REG_DIFF_ENABLE, 1);
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_CONV_SCHEME, s);
      // all-max and all-min stencils
      send_request({11{32'h7fffffff}});
      send_request({11{32'h80000000}});
      // flat stencil: zero denominators, zero numerators
      it = {{5{32'h00010000}}, 32'h00010000, 32'hffff0000, {3{32'h00010000}}, 32'h0};
      send_request(it);
      // rising stencil, zero velocities (treated as eastward)
      it = {32'h0, 32'h10000, 32'h20000, 32'h40000, 32'h80000,
            32'h0, 32'h0, 32'h10000, 32'h20000, 32'h30000, 32'h8000};
      send_request(it);
      // opposite-sign ratio, negative velocities
      it = {32'h30000, 32'h10000, 32'h20000, 32'h10000, 32'h30000,
            32'hfffe0000, 32'hfff00000, 32'h10000, 32'h10000, 32'h10000, 32'hffff8000};
      send_request(it);
      end_burst();
      drain();
    end
    write_reg(REG_SRC_ENABLE, 0);
    write_reg(REG_FACE_AREA, 32'hffffffff);
    write_reg(REG_INV_CELL_WIDTH, 32'hffffffff);
    send_request({11{32'h7fffffff}});
    send_request({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff});
    end_burst();
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 31; ph++) begin
      random_config();
      if (ph >= 27) idle_enable = 0;
      for (int n = 0; n < 50; n++) send_request(rand_item());
      end_burst();
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
